// File: rtl/gbr_pkg.sv
// Shared types, constants and the 1-2-1 blur kernel for the RGB Gaussian blur block.
package gbr_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int IMG_W_BITS = 11;
  localparam int IMG_H_BITS = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int MIN_DIM    = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  // Input action codes
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;
  localparam int FIFO_ROOM  = 2;

  typedef logic [PIX_W-1:0] pix_t;

  // One window column: top, middle and bottom row
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // Item held between the control stage and the window stage
  typedef struct packed {
    logic vld;
    logic drain;
    logic first;
    logic row0;
    logic emit1;
    logic emit2;
    logic last;
    pix_t pix;
  } op_t;

  typedef struct packed {
    pix_t pix;
    logic last;
  } res_t;

  // Weighted sum of the 3x3 window per channel, divided by 16.
  // The sum tops out at 16 * 255, so the quotient cannot exceed 255.
  function automatic pix_t blur3(input col_t l, input col_t m, input col_t r);
    pix_t        res;
    logic [11:0] s;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      s = 12'(l.top[ch*CH_W +: CH_W]) + (12'(l.mid[ch*CH_W +: CH_W]) << 1)
        + 12'(l.bot[ch*CH_W +: CH_W])
        + (12'(m.top[ch*CH_W +: CH_W]) << 1) + (12'(m.mid[ch*CH_W +: CH_W]) << 2)
        + (12'(m.bot[ch*CH_W +: CH_W]) << 1)
        + 12'(r.top[ch*CH_W +: CH_W]) + (12'(r.mid[ch*CH_W +: CH_W]) << 1)
        + 12'(r.bot[ch*CH_W +: CH_W]);
      res[ch*CH_W +: CH_W] = s[11:4];
    end
    return res;
  endfunction

endpackage

// File: rtl/gbr_if.sv
// Valid/ready stream interfaces for the pixel input and the blurred result output.
interface gbr_in_if;
  import gbr_pkg::*;
  logic            valid;
  logic            ready;
  logic            action;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, action, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface gbr_out_if;
  import gbr_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            last_out;

  modport source (output valid, red_out, green_out, blue_out, last_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, last_out, output ready);
endinterface

// File: rtl/gbr_ctrl.sv
// Configuration registers, frame counters and per-item decode into the window stage.
module gbr_ctrl #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gbr_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [gbr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             acc,
  input  logic                             action,
  input  gbr_pkg::pix_t                    pix,
  output logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
  output gbr_pkg::op_t                     op_r,
  output logic [$clog2(MAX_WIDTH)-1:0]     addr_r
);
  import gbr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CW-1:0]         wlast_r, wlast_nxt;
  logic [IMG_H_BITS-1:0] h_r, h_nxt;
  logic [IMG_H_BITS-1:0] row_r, row_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [CW-1:0]         drn_r, drn_nxt;
  op_t                   op_nxt;
  logic [CW-1:0]         addr_nxt;
  logic [IMG_W_BITS-1:0] wraw;
  logic [IMG_H_BITS-1:0] hraw;
  logic                  all_rows;

  always_comb begin
    wraw      = cfg_data[IMG_W_BITS-1:0];
    hraw      = cfg_data[IMG_H_BITS-1:0];
    all_rows  = (row_r >= h_r);
    wlast_nxt = wlast_r;
    h_nxt     = h_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    drn_nxt   = drn_r;
    rd_addr   = col_r;
    addr_nxt  = col_r;
    op_nxt    = '0;
    op_nxt.pix = pix;

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IDX_WIDTH: begin
          if (wraw < IMG_W_BITS'(MIN_DIM)) begin
            wlast_nxt = CW'(MIN_DIM - 1);
          end else if (32'(wraw) > MAX_WIDTH) begin
            wlast_nxt = CW'(MAX_WIDTH - 1);
          end else begin
            wlast_nxt = CW'(32'(wraw) - 32'd1);
          end
        end
        CFG_IDX_HEIGHT: begin
          h_nxt = (hraw < IMG_H_BITS'(MIN_DIM)) ? IMG_H_BITS'(MIN_DIM) : hraw;
        end
      endcase
      // any write restarts the frame
      row_nxt = '0;
      col_nxt = '0;
      drn_nxt = '0;
    end else if (acc) begin
      if (action == ACT_PIXEL) begin
        if (!all_rows) begin
          op_nxt.vld   = 1'b1;
          op_nxt.row0  = (row_r == '0);
          op_nxt.first = (col_r == '0);
          op_nxt.emit1 = (row_r != '0) && (col_r != '0);
          op_nxt.emit2 = (row_r != '0) && (col_r == wlast_r);
          if (col_r == wlast_r) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end else begin
        // fetch the right-hand column of the drain window, clamped at the row end
        rd_addr  = (drn_r == wlast_r) ? wlast_r : drn_r + 1'b1;
        addr_nxt = rd_addr;
        if (all_rows) begin
          op_nxt.vld   = 1'b1;
          op_nxt.drain = 1'b1;
          op_nxt.first = (drn_r == '0);
          op_nxt.emit1 = 1'b1;
          op_nxt.last  = (drn_r == wlast_r);
          if (drn_r == wlast_r) begin
            row_nxt = '0;
            col_nxt = '0;
            drn_nxt = '0;
          end else begin
            drn_nxt = drn_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= CW'(MIN_DIM - 1);
      h_r     <= IMG_H_BITS'(MIN_DIM);
      row_r   <= '0;
      col_r   <= '0;
      drn_r   <= '0;
      op_r    <= '0;
    end else begin
      wlast_r <= wlast_nxt;
      h_r     <= h_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      drn_r   <= drn_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

endmodule

// File: rtl/gbr_line_store.sv
// Two line memories: previous row and the row before it, registered reads.
module gbr_line_store #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  gbr_pkg::pix_t                wr_b,
  input  gbr_pkg::pix_t                wr_a,
  output gbr_pkg::pix_t                rd_b_r,
  output gbr_pkg::pix_t                rd_a_r
);
  import gbr_pkg::*;

  pix_t mem_a [MAX_WIDTH];
  pix_t mem_b [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_a;
      mem_b[wr_addr] <= wr_b;
    end
    rd_a_r <= mem_a[rd_addr];
    rd_b_r <= mem_b[rd_addr];
  end

endmodule

// File: rtl/gbr_window.sv
// 3x3 window registers, line store write-back and the blur of one or two results.
module gbr_window (
  input  logic                clk,
  input  gbr_pkg::op_t        op,
  input  gbr_pkg::pix_t       rd_b,
  input  gbr_pkg::pix_t       rd_a,
  output logic                wr_en,
  output gbr_pkg::pix_t       wr_b,
  output gbr_pkg::pix_t       wr_a,
  output logic [1:0]          push_cnt,
  output gbr_pkg::res_t       res0,
  output gbr_pkg::res_t       res1
);
  import gbr_pkg::*;

  col_t [2:0] win_r, win_nxt;  // index 0 is the left column
  pix_t       hd_b_r, hd_a_r;  // column 0 of both stores, seeds the drain window
  pix_t       top, mid;
  col_t       ncol, hcol;

  always_comb begin
    top  = op.row0 ? op.pix : rd_b;
    mid  = op.row0 ? op.pix : rd_a;
    ncol = op.drain ? col_t'{rd_b, rd_a, rd_a} : col_t'{top, mid, op.pix};
    hcol = col_t'{hd_b_r, hd_a_r, hd_a_r};

    win_nxt = win_r;
    if (op.vld) begin
      if (op.first && !op.drain) begin
        win_nxt[0] = ncol;
        win_nxt[1] = ncol;
        win_nxt[2] = ncol;
      end else if (op.first) begin
        win_nxt[0] = hcol;
        win_nxt[1] = hcol;
        win_nxt[2] = ncol;
      end else begin
        win_nxt[0] = win_r[1];
        win_nxt[1] = win_r[2];
        win_nxt[2] = ncol;
      end
    end

    wr_en = op.vld && !op.drain;
    wr_b  = mid;
    wr_a  = op.pix;

    res0.pix  = blur3(win_nxt[0], win_nxt[1], win_nxt[2]);
    res0.last = op.last;
    // row end: replicate the right column for the final pixel of the row
    res1.pix  = blur3(win_nxt[1], win_nxt[2], win_nxt[2]);
    res1.last = 1'b0;

    push_cnt = op.vld ? (2'(op.emit1) + 2'(op.emit2)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (op.vld && !op.drain && op.first) begin
      hd_b_r <= mid;
      hd_a_r <= op.pix;
    end
  end

endmodule

// File: rtl/gbr_out_fifo.sv
// Four-entry result queue taking up to two results per cycle, one out per transfer.
module gbr_out_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [1:0]                        push_cnt,
  input  gbr_pkg::res_t                     res0,
  input  gbr_pkg::res_t                     res1,
  input  logic                              pop,
  output gbr_pkg::res_t                     head,
  output logic [gbr_pkg::FIFO_CNT_W-1:0]    cnt_r
);
  import gbr_pkg::*;

  res_t                  q_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, rp_r;
  logic [FIFO_PTR_W-1:0] wp1;

  assign wp1  = wp_r + 1'b1;
  assign head = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + FIFO_PTR_W'(push_cnt);
      rp_r  <= rp_r + FIFO_PTR_W'(pop);
      cnt_r <= cnt_r + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q_r[wp_r] <= res0;
    end
    if (push_cnt == 2'd2) begin
      q_r[wp1] <= res1;
    end
  end

endmodule

// File: rtl/gaussian_blur_3x3_rgb.sv
// Top level of the streaming 3x3 RGB Gaussian blur with line stores and result queue.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------------
//   in_if    | in  | valid / ready      | action, red_in, green_in, blue_in
//   out_if   | out | valid / ready      | red_out, green_out, blue_out, last_out
//   cfg_*    | in  | cfg_we, no stall   | cfg_idx, cfg_data
//
// One input item per cycle while ready is high; results pass op_r and then the queue.
// An item at the last column of any row but the first yields two results, so
// the output side pops twice for it and the four-entry queue backs up the input.
// Line store reads are one port per memory, registered, one column per item.
// Synchronous reset clears counters and the queue; line stores need no clearing.
module gaussian_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gbr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [gbr_pkg::CFG_DATA_W-1:0]  cfg_data,
  gbr_in_if.sink                          in_if,
  gbr_out_if.source                       out_if
);
  import gbr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic                  acc;
  pix_t                  in_pix;
  logic [CW-1:0]         rd_addr;
  logic [CW-1:0]         addr_r;
  op_t                   op;
  logic                  wr_en;
  pix_t                  wr_b, wr_a;
  pix_t                  rd_b, rd_a;
  logic [1:0]            push_cnt;
  res_t                  res0, res1, head;
  logic                  pop;
  logic [FIFO_CNT_W-1:0] cnt;

  assign in_pix = {in_if.red_in, in_if.green_in, in_if.blue_in};
  assign acc    = in_if.valid && in_if.ready;
  // hold off unless the queue can take two more results after the pending ones
  assign in_if.ready = (({1'b0, cnt} + (FIFO_CNT_W + 1)'(push_cnt))
                        <= (FIFO_CNT_W + 1)'(FIFO_ROOM));

  assign out_if.valid     = (cnt != '0);
  assign out_if.red_out   = head.pix[3*CH_W-1:2*CH_W];
  assign out_if.green_out = head.pix[2*CH_W-1:CH_W];
  assign out_if.blue_out  = head.pix[CH_W-1:0];
  assign out_if.last_out  = head.last;
  assign pop              = out_if.valid && out_if.ready;

  gbr_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .acc      (acc),
    .action   (in_if.action),
    .pix      (in_pix),
    .rd_addr  (rd_addr),
    .op_r     (op),
    .addr_r   (addr_r)
  );

  gbr_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_b    (wr_b),
    .wr_a    (wr_a),
    .rd_b_r  (rd_b),
    .rd_a_r  (rd_a)
  );

  gbr_window u_window (
    .clk      (clk),
    .op       (op),
    .rd_b     (rd_b),
    .rd_a     (rd_a),
    .wr_en    (wr_en),
    .wr_b     (wr_b),
    .wr_a     (wr_a),
    .push_cnt (push_cnt),
    .res0     (res0),
    .res1     (res1)
  );

  gbr_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .res0     (res0),
    .res1     (res1),
    .pop      (pop),
    .head     (head),
    .cnt_r    (cnt)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_drain_single: assert property (@(posedge clk) disable iff (!rst_n)
    op.vld && op.drain |-> push_cnt == 2'd1)
    else $error("drain item must produce exactly one result");

  a_last_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    op.vld && op.last |-> op.drain && $past(acc))
    else $error("frame end marked outside a drain transfer");

endmodule
